FILE: rtl/sic_pkg.sv
// shared types, constants and codes for the stack integer calculator
`default_nettype none
package sic_pkg;
    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int IDX_W       = 10;
    localparam int DIV_CNT_W   = $clog2(WORD_W + 1);

    typedef enum logic [2:0] {
        M_PUSH = 3'd0, M_POP = 3'd1, M_PEEK_TOP = 3'd2, M_PEEK_BOT = 3'd3,
        M_ADD = 3'd4, M_SUB = 3'd5, M_MUL = 3'd6, M_DIV = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_RANGE = 3'd3,
        ST_FEW = 3'd4, ST_DIVZERO = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_PEEK, S_WAIT_PEEK, S_RD_RIGHT, S_RD_LEFT, S_WAIT_LEFT,
        S_ARITH, S_MUL_WAIT, S_DIV_RUN, S_DIV_FIX, S_WRITE, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        A_PUSH, A_POP, A_RD_TOP, A_RD_IDX
    } t_addr_sel;

    // controller to datapath
    typedef struct packed {
        logic      load_in;
        logic      mem_re;
        t_addr_sel addr_sel;
        logic      mem_we_push;
        logic      mem_we_res;
        logic      take_right;
        logic      take_left;
        logic      take_value;
        logic      arith_go;
        logic      mul_go;
        logic      div_go;
        logic      div_step;
        logic      div_fix;
        logic      depth_inc;
        logic      depth_dec;
        logic      depth_dec2;
        logic      clr_value;
        logic      peek_bot;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  empty;
        logic  idx_bad;
        logic  few;
        logic  right_zero;
        logic  div_done;
    } t_stat;
endpackage
`default_nettype wire

FILE: rtl/sic_ram.sv
// generic single-port ram with registered read
`default_nettype none
module sic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/sic_datapath.sv
// operand registers, stack memory, depth counter, multiplier and serial divider
`default_nettype none
module sic_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sic_pkg::t_ctrl                i_ctrl,
    input  wire logic [2:0]                    i_mode,
    input  wire logic signed [31:0]            i_push_value,
    input  wire logic [9:0]                    i_peek_index,
    output sic_pkg::t_stat                     o_stat,
    output logic signed [31:0]                 o_value,
    output logic [10:0]                        o_depth
);
    import sic_pkg::*;

    logic [DEPTH_W-1:0] r_depth;
    t_mode              r_mode;
    logic [WORD_W-1:0]  r_pval, r_right, r_left, r_res, r_value;
    logic [IDX_W-1:0]   r_idx;
    logic [ADDR_W-1:0]  addr;
    logic [WORD_W-1:0]  rdata, wdata;
    logic               we;
    // divider
    logic [WORD_W-1:0]  r_q, r_rem, r_dm;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic               r_neg;
    logic [WORD_W:0]    trial;
    logic [WORD_W-1:0]  rem_sh;
    logic [WORD_W-1:0]  lm, rm;
    logic [DEPTH_W-1:0] idx_ext;
    logic [DEPTH_W-1:0] top_addr;
    logic [DEPTH_W-1:0] tos_addr;

    assign idx_ext  = DEPTH_W'(r_idx);
    assign tos_addr = r_depth - DEPTH_W'(1);
    assign top_addr = r_depth - DEPTH_W'(1) - idx_ext;

    always_comb begin
        unique case (i_ctrl.addr_sel)
            A_PUSH:   addr = r_depth[ADDR_W-1:0];
            A_POP:    addr = tos_addr[ADDR_W-1:0];
            A_RD_TOP: addr = tos_addr[ADDR_W-1:0];
            A_RD_IDX: addr = i_ctrl.peek_bot ? r_idx[ADDR_W-1:0] : top_addr[ADDR_W-1:0];
            default:  addr = r_depth[ADDR_W-1:0];
        endcase
    end

    assign we    = i_ctrl.mem_we_push | i_ctrl.mem_we_res;
    assign wdata = i_ctrl.mem_we_push ? r_pval : r_res;

    sic_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk, .i_we(we), .i_re(i_ctrl.mem_re), .i_addr(addr),
        .i_wdata(wdata), .o_rdata(rdata)
    );

    assign lm     = r_left[WORD_W-1] ? (~r_left + 1'b1) : r_left;
    assign rm     = r_right[WORD_W-1] ? (~r_right + 1'b1) : r_right;
    assign rem_sh = {r_rem[WORD_W-2:0], r_q[WORD_W-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, r_dm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            if (i_ctrl.depth_inc)       r_depth <= r_depth + DEPTH_W'(1);
            else if (i_ctrl.depth_dec)  r_depth <= r_depth - DEPTH_W'(1);
            else if (i_ctrl.depth_dec2) r_depth <= r_depth - DEPTH_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_mode <= t_mode'(i_mode);
            r_pval <= i_push_value;
            r_idx  <= i_peek_index;
        end
        if (i_ctrl.take_right) r_right <= rdata;
        if (i_ctrl.take_left)  r_left  <= rdata;
        if (i_ctrl.clr_value)       r_value <= '0;
        else if (i_ctrl.take_value) r_value <= rdata;
        else if (i_ctrl.mem_we_res) r_value <= r_res;
        if (i_ctrl.arith_go) begin
            if (r_mode == M_ADD) r_res <= r_left + r_right;
            else                 r_res <= r_left - r_right;
        end
        if (i_ctrl.mul_go) r_res <= WORD_W'(r_left * r_right);
        if (i_ctrl.div_go) begin
            r_q   <= lm;
            r_rem <= '0;
            r_dm  <= rm;
            r_cnt <= DIV_CNT_W'(WORD_W);
            r_neg <= r_left[WORD_W-1] ^ r_right[WORD_W-1];
        end else if (i_ctrl.div_step) begin
            r_cnt <= r_cnt - 1'b1;
            if (!trial[WORD_W]) begin
                r_rem <= trial[WORD_W-1:0];
                r_q   <= {r_q[WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[WORD_W-2:0], 1'b0};
            end
        end
        if (i_ctrl.div_fix) begin
            // floored: negate, and step down once more on a nonzero remainder
            if (r_neg) r_res <= ~r_q + ((r_rem != '0) ? WORD_W'(0) : WORD_W'(1));
            else       r_res <= r_q;
        end
    end

    assign o_stat.mode       = r_mode;
    assign o_stat.full       = (r_depth >= DEPTH_W'(STACK_DEPTH));
    assign o_stat.empty      = (r_depth == '0);
    assign o_stat.idx_bad    = (idx_ext >= r_depth);
    assign o_stat.few        = (r_depth < DEPTH_W'(2));
    assign o_stat.right_zero = (r_right == '0);
    assign o_stat.div_done   = (r_cnt == '0);
    assign o_value = r_value;
    assign o_depth = 11'(r_depth);
endmodule
`default_nettype wire

FILE: rtl/sic_ctrl.sv
// sequencing state machine and output beat register
`default_nettype none
module sic_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire sic_pkg::t_stat i_stat,
    output sic_pkg::t_ctrl      o_ctrl,
    output logic [2:0]          o_status,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic                o_capture
);
    import sic_pkg::*;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_valid  = r_valid;
        o_ctrl   = '0;
        o_ctrl.peek_bot = (i_stat.mode == M_PEEK_BOT);
        o_ctrl.addr_sel = A_RD_TOP;
        o_capture = 1'b0;
        o_stall  = 1'b1;
        if (r_valid && !i_stall) n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_ctrl.load_in = 1'b1;
                    n_state = S_RD_PEEK;
                end
            end
            S_RD_PEEK: begin
                n_status = ST_OK;
                o_ctrl.clr_value = 1'b1;
                unique case (i_stat.mode)
                    M_PUSH: begin
                        if (i_stat.full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_ctrl.addr_sel = A_PUSH;
                            o_ctrl.mem_we_push = 1'b1;
                            o_ctrl.depth_inc = 1'b1;
                        end
                        n_state = S_OUT;
                    end
                    M_POP: begin
                        if (i_stat.empty) begin
                            n_status = ST_EMPTY;
                            n_state = S_OUT;
                        end else begin
                            o_ctrl.mem_re = 1'b1;
                            o_ctrl.depth_dec = 1'b1;
                            n_state = S_WAIT_PEEK;
                        end
                    end
                    M_PEEK_TOP, M_PEEK_BOT: begin
                        if (i_stat.idx_bad) begin
                            n_status = ST_RANGE;
                            n_state = S_OUT;
                        end else begin
                            o_ctrl.addr_sel = A_RD_IDX;
                            o_ctrl.mem_re = 1'b1;
                            n_state = S_WAIT_PEEK;
                        end
                    end
                    default: begin
                        if (i_stat.few) begin
                            n_status = ST_FEW;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_RD_RIGHT;
                        end
                    end
                endcase
            end
            S_WAIT_PEEK: begin
                o_ctrl.take_value = 1'b1;
                n_state = S_OUT;
            end
            S_RD_RIGHT: begin
                // read top, then drop depth by one so the next read is the left word
                o_ctrl.mem_re = 1'b1;
                o_ctrl.depth_dec = 1'b1;
                n_state = S_RD_LEFT;
            end
            S_RD_LEFT: begin
                o_ctrl.take_right = 1'b1;
                o_ctrl.mem_re = 1'b1;
                o_ctrl.depth_dec = 1'b1;
                n_state = S_WAIT_LEFT;
            end
            S_WAIT_LEFT: begin
                o_ctrl.take_left = 1'b1;
                n_state = S_ARITH;
            end
            S_ARITH: begin
                unique case (i_stat.mode)
                    M_MUL: begin
                        o_ctrl.mul_go = 1'b1;
                        n_state = S_MUL_WAIT;
                    end
                    M_DIV: begin
                        if (i_stat.right_zero) begin
                            n_status = ST_DIVZERO;
                            n_state = S_OUT;
                        end else begin
                            o_ctrl.div_go = 1'b1;
                            n_state = S_DIV_RUN;
                        end
                    end
                    default: begin
                        o_ctrl.arith_go = 1'b1;
                        n_state = S_WRITE;
                    end
                endcase
            end
            S_MUL_WAIT: n_state = S_WRITE;
            S_DIV_RUN: begin
                if (i_stat.div_done) n_state = S_DIV_FIX;
                else o_ctrl.div_step = 1'b1;
            end
            S_DIV_FIX: begin
                o_ctrl.div_fix = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_ctrl.addr_sel = A_PUSH;
                o_ctrl.mem_we_res = 1'b1;
                o_ctrl.depth_inc = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // wait for the output register to be free
                if (!r_valid || !i_stall) begin
                    o_capture = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
endmodule
`default_nettype wire

FILE: rtl/stack_integer_calculator.sv
// top level of the stack integer calculator
// Postfix integer calculator over a 1024-word operand stack.
// Input channel: i_valid / o_stall with i_mode, i_push_value, i_peek_index.
// Output channel: o_valid / i_stall with o_result_value, o_status, o_depth.
// A beat is taken only while the controller is idle; one result beat follows
// every input beat.
// The serial divider forms 32 quotient bits, one per cycle, and then applies
// a sign fix. A new beat is taken the cycle after the result is loaded into
// the output register.
// The stack lives in one single-port RAM, so operand reads are serialized.
// Reset clears the depth to zero and drops any pending result; stack words
// need no clearing since only written entries are read.
// While the receiver stalls, the result holds; the next item may be worked
// on but waits for the output register before its result is loaded.
`default_nettype none
module stack_integer_calculator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_mode,
    input  wire logic signed [31:0] i_push_value,
    input  wire logic [9:0]         i_peek_index,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_result_value,
    output logic [2:0]              o_status,
    output logic [10:0]             o_depth
);
    import sic_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic  capture;
    logic signed [31:0] value;
    logic [10:0] depth;
    logic [2:0]  status;
    logic signed [31:0] r_out_value;
    logic [10:0] r_out_depth;
    logic [2:0]  r_out_status;

    sic_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_stat(stat), .o_ctrl(ctrl),
        .o_status(status), .o_valid, .i_stall, .o_capture(capture)
    );

    sic_datapath u_dp (
        .i_clk, .i_rst_n, .i_ctrl(ctrl), .i_mode, .i_push_value, .i_peek_index,
        .o_stat(stat), .o_value(value), .o_depth(depth)
    );

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_out_value  <= value;
            r_out_depth  <= depth;
            r_out_status <= status;
        end
    end

    assign o_result_value = r_out_value;
    assign o_depth        = r_out_depth;
    assign o_status       = r_out_status;
endmodule
`default_nettype wire

FILE: rtl/sic_checker.sv
// port-level checker for the stack integer calculator, bound to the top level
`default_nettype none
module sic_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_status,
    input wire logic [10:0] o_depth
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_depth))
        else $error("stalled result changed");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= 3'd5)
        else $error("bad status code");
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_depth <= 11'd1024)
        else $error("depth beyond stack size");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second beat accepted while busy");
endmodule

bind stack_integer_calculator sic_checker u_sic_checker (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_status, .o_depth
);
`default_nettype wire
